FILE: src/fccl_pkg.sv
// shared constants, codes and types of the fat12 cluster chain lookup core
`timescale 1ns / 1ps
package fccl_pkg;

	localparam int TABLE_BYTES = 8192;
	localparam int ADDR_W      = $clog2(TABLE_BYTES);
	localparam int BANK_DEPTH  = TABLE_BYTES / 2;
	localparam int BANK_AW     = $clog2(BANK_DEPTH);
	localparam int BYTE_W      = 8;
	localparam int CLUSTER_W   = 12;
	localparam int LBA_W       = 32;
	localparam int BASE_W      = 18;
	localparam int SPC_W       = 8;
	localparam int PROD_W      = CLUSTER_W + SPC_W;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 48;

	localparam logic [CLUSTER_W-1:0] END_MARK = 12'hFF0;

	localparam logic [15:0] RESERVED_RST = 16'd1;
	localparam logic [7:0]  FAT_SIZE_RST = 8'd9;
	localparam logic [7:0]  FAT_COUNT_RST = 8'd2;
	localparam logic [15:0] ROOT_RST     = 16'd224;
	localparam logic [7:0]  SPC_RST      = 8'd1;

	typedef enum logic {
		CMD_WRITE  = 1'b0,
		CMD_LOOKUP = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RESERVED  = 3'd0,
		REG_FAT_SIZE  = 3'd1,
		REG_FAT_COUNT = 3'd2,
		REG_ROOT      = 3'd3,
		REG_SPC       = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [BASE_W-1:0] base;
		logic [SPC_W-1:0]  spc;
	} geom_t;

endpackage

FILE: src/fccl_ram.sv
// generic single-write single-read synchronous ram with a registered read port
`timescale 1ns / 1ps
module fccl_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: src/fccl_cfg.sv
// geometry registers and the registered data area base sector
`timescale 1ns / 1ps
module fccl_cfg
	import fccl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output geom_t                 geom
);

	logic [15:0]       reserved_q;
	logic [7:0]        fat_size_q;
	logic [7:0]        fat_count_q;
	logic [15:0]       root_q;
	logic [SPC_W-1:0]  spc_q;
	logic [BASE_W-1:0] base_q;
	logic [15:0]       fat_area;
	logic [BASE_W-1:0] base_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q  <= RESERVED_RST;
			fat_size_q  <= FAT_SIZE_RST;
			fat_count_q <= FAT_COUNT_RST;
			root_q      <= ROOT_RST;
			spc_q       <= SPC_RST;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_RESERVED:  reserved_q  <= cfg_data;
				REG_FAT_SIZE:  fat_size_q  <= cfg_data[7:0];
				REG_FAT_COUNT: fat_count_q <= cfg_data[7:0];
				REG_ROOT:      root_q      <= cfg_data;
				REG_SPC:       spc_q       <= cfg_data[SPC_W-1:0];
				default:       ;
			endcase
		end
	end

	// root directory sectors: entries * 32 / 512
	always_comb begin
		fat_area = fat_size_q * fat_count_q;
		base_d   = BASE_W'(reserved_q) + BASE_W'(1) + BASE_W'(fat_area)
			+ BASE_W'(root_q[15:4]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else begin
			base_q <= base_d;
		end
	end

	assign geom.base = base_q;
	assign geom.spc  = spc_q;

endmodule

FILE: src/fccl_result.sv
// assembles the table entry, the end of chain flag and the first sector
`timescale 1ns / 1ps
module fccl_result
	import fccl_pkg::*;
(
	input  logic [BYTE_W-1:0]    even_byte,
	input  logic [BYTE_W-1:0]    odd_byte,
	input  logic                 swap,
	input  logic [CLUSTER_W-1:0] cluster,
	input  geom_t                geom,
	output logic [CLUSTER_W-1:0] next_cluster,
	output logic                 chain_end,
	output logic [LBA_W-1:0]     first_sector
);

	logic [15:0]          word;
	logic [CLUSTER_W-1:0] rel;
	logic [PROD_W-1:0]    prod;

	always_comb begin
		word = swap ? {even_byte, odd_byte} : {odd_byte, even_byte};
		next_cluster = cluster[0] ? word[15:4] : word[CLUSTER_W-1:0];
		chain_end = (next_cluster == '0) || ((next_cluster & END_MARK) == END_MARK);
		rel  = cluster - CLUSTER_W'(2);
		prod = PROD_W'(rel) * PROD_W'(geom.spc);
		if (cluster < CLUSTER_W'(2)) begin
			first_sector = '0;
		end else begin
			first_sector = LBA_W'(prod) + LBA_W'(geom.base);
		end
	end

endmodule

FILE: src/fat12_cluster_chain_lookup_core.sv
// top level: banked fat byte store, lookup pipeline and output register
//
// The table is held in two 4096-byte banks, even and odd offsets, so the two
// bytes of a 12-bit entry come out of one read. A table write request gives
// no result; a lookup request passes the registered ram read and then entry
// and sector assembly into the output register. One request is accepted
// every cycle while s_tready is high; s_tready drops only while both the
// read stage and the output register hold untaken results. A lookup right
// after a write to the same bytes sees the new data, since the write lands
// at the edge before the read.
`timescale 1ns / 1ps
module fat12_cluster_chain_lookup_core
	import fccl_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// table_address[12:0], table_byte[20:13], cluster_number[32:21], zero pad
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// cmd
	input  logic                   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// next_cluster[11:0], chain_end[12], first_sector[44:13], zero pad
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	geom_t                geom;
	logic                 s_fire;
	logic                 is_lookup;
	logic                 advance;
	logic [ADDR_W-1:0]    wr_addr;
	logic [BYTE_W-1:0]    wr_byte;
	logic [CLUSTER_W-1:0] cluster_in;
	logic [ADDR_W-1:0]    offset;
	logic [BANK_AW-1:0]   even_rd_addr;
	logic [BANK_AW-1:0]   odd_rd_addr;
	logic                 even_we;
	logic                 odd_we;
	logic                 rd_en;
	logic [BYTE_W-1:0]    even_data;
	logic [BYTE_W-1:0]    odd_data;

	logic                 valid_s1;
	logic [CLUSTER_W-1:0] cluster_s1;
	logic                 swap_s1;

	logic [CLUSTER_W-1:0] next_d;
	logic                 chain_end_d;
	logic [LBA_W-1:0]     lba_d;
	logic                 out_valid_q;
	logic [CLUSTER_W-1:0] next_q;
	logic                 chain_end_q;
	logic [LBA_W-1:0]     lba_q;

	assign cfg_ready = 1'b1;

	fccl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom)
	);

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign s_fire   = s_tvalid && s_tready;

	always_comb begin
		is_lookup    = (cmd_t'(s_tuser) == CMD_LOOKUP);
		wr_addr      = s_tdata[ADDR_W-1:0];
		wr_byte      = s_tdata[ADDR_W+BYTE_W-1:ADDR_W];
		cluster_in   = s_tdata[ADDR_W+BYTE_W+CLUSTER_W-1:ADDR_W+BYTE_W];
		// byte offset of the entry: cluster * 3 / 2
		offset       = ADDR_W'(cluster_in) + ADDR_W'(cluster_in[CLUSTER_W-1:1]);
		odd_rd_addr  = offset[ADDR_W-1:1];
		even_rd_addr = offset[ADDR_W-1:1] + BANK_AW'(offset[0]);
		even_we      = s_fire && !is_lookup && !wr_addr[0];
		odd_we       = s_fire && !is_lookup && wr_addr[0];
		rd_en        = s_fire && is_lookup;
	end

	fccl_ram #(
		.DEPTH (BANK_DEPTH),
		.WIDTH (BYTE_W)
	) u_even_bank (
		.clk     (clk),
		.wr_en   (even_we),
		.wr_addr (wr_addr[ADDR_W-1:1]),
		.wr_data (wr_byte),
		.rd_en   (rd_en),
		.rd_addr (even_rd_addr),
		.rd_data (even_data)
	);

	fccl_ram #(
		.DEPTH (BANK_DEPTH),
		.WIDTH (BYTE_W)
	) u_odd_bank (
		.clk     (clk),
		.wr_en   (odd_we),
		.wr_addr (wr_addr[ADDR_W-1:1]),
		.wr_data (wr_byte),
		.rd_en   (rd_en),
		.rd_addr (odd_rd_addr),
		.rd_data (odd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= is_lookup;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			cluster_s1 <= cluster_in;
			swap_s1    <= offset[0];
		end
	end

	fccl_result u_result (
		.even_byte    (even_data),
		.odd_byte     (odd_data),
		.swap         (swap_s1),
		.cluster      (cluster_s1),
		.geom         (geom),
		.next_cluster (next_d),
		.chain_end    (chain_end_d),
		.first_sector (lba_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			next_q      <= next_d;
			chain_end_q <= chain_end_d;
			lba_q       <= lba_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_TDATA_W-LBA_W-CLUSTER_W-1)'(0), lba_q, chain_end_q, next_q};

`ifndef ASSERT_OFF
	a_lookup_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && is_lookup |=> valid_s1)
		else $error("accepted lookup did not reach the read stage");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && !is_lookup |=> !valid_s1)
		else $error("table write produced a pending lookup");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(cluster_s1) && $stable(swap_s1))
		else $error("stalled lookup lost its state");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |-> !s_tready)
		else $error("request accepted while read stage is blocked");

	a_chain_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> chain_end_q == ((next_q == '0) || (next_q[11:4] == 8'hFF)))
		else $error("chain end flag disagrees with next cluster");
`endif

endmodule
